[rtl/core/kpad_pkg.sv]
// Shared constants, key table and types for the keypad click and autorepeat block.
`timescale 1ns / 1ps

package kpad_pkg;

  // Field widths fixed by the interface.
  localparam int KEY_W   = 16;
  localparam int TICK_W  = 32;
  localparam int POS_W   = 4;
  localparam int DELAY_W = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = DELAY_W;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD = 1'd1;

  // Register values after reset.
  localparam logic [DELAY_W-1:0] FIRST_DELAY_RST   = 16'd500;
  localparam logic [DELAY_W-1:0] REPEAT_PERIOD_RST = 16'd175;

  // Defaults for the top-level parameters.
  localparam int NUM_KEYS_DEF = 12;
  localparam int KEY_BITS_DEF = 16;

  // Priority table of key masks, position 1 first.
  localparam int TABLE_LEN = 12;
  localparam logic [KEY_W-1:0] KEY_MASKS [TABLE_LEN] = '{
    16'h0020, 16'h0040, 16'h0080, 16'h0100,
    16'h0200, 16'h0006, 16'h0002, 16'h0008,
    16'h0010, 16'h0400, 16'h0800, 16'h2000
  };

  // Table position, 0 means no key.
  typedef logic [POS_W-1:0] key_pos_t;

  // Result of matching one key word against the table.
  typedef struct packed {
    key_pos_t pressed;
    key_pos_t clicked;
    logic     held_down;
  } match_t;

endpackage

[rtl/core/keypad_click_and_autorepeat.sv]
// Keypad click detection and key autorepeat, top level.
//
// Usage: each item on the in_ channel is one keypad poll: the raw active-low
// key word, the current tick count and a flag that disarms autorepeat. For
// every accepted item exactly one result item leaves on the out_ channel with
// the first pressed key, the first newly clicked key and the key reported by
// click or autorepeat, all as table positions with 0 meaning none.
// The result of an item accepted at one edge is valid in the single output
// register after that edge. Throughput is one item per cycle while the
// receiver does not stall; the key history and autorepeat state are updated
// at the accepting edge, so the next poll can follow immediately.
// When the receiver stalls, the result waits in the output register and
// in_stall rises only while that register is full and stalled; it falls in
// the cycle the result is taken.
// Reset clears the key history, disarms autorepeat, sets the delays to 500
// and 175 ticks and empties the output register. The cfg_ port writes the
// first delay (index 0) and the repeat period (index 1) at any cycle with
// cfg_we high; writes are expected only while the block is idle.
`timescale 1ns / 1ps

module keypad_click_and_autorepeat #(
  parameter int NUM_KEYS = kpad_pkg::NUM_KEYS_DEF,
  parameter int KEY_BITS = kpad_pkg::KEY_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Poll channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [kpad_pkg::KEY_W-1:0]         in_key_word,
  input  logic [kpad_pkg::TICK_W-1:0]        in_now,
  input  logic                               in_clear_repeat,
  // Result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output kpad_pkg::key_pos_t                 out_pressed_key,
  output kpad_pkg::key_pos_t                 out_clicked_key,
  output kpad_pkg::key_pos_t                 out_repeat_key,
  // Configuration port
  input  logic                               cfg_we,
  input  logic [kpad_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kpad_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int ACTIVE = (NUM_KEYS < kpad_pkg::TABLE_LEN) ? NUM_KEYS : kpad_pkg::TABLE_LEN;
  localparam logic [kpad_pkg::KEY_W-1:0] WORD_MASK =
    (KEY_BITS >= kpad_pkg::KEY_W) ? {kpad_pkg::KEY_W{1'b1}}
                                  : kpad_pkg::KEY_W'((64'd1 << KEY_BITS) - 64'd1);

  // Configuration registers.
  logic [kpad_pkg::DELAY_W-1:0] first_delay_r;
  logic [kpad_pkg::DELAY_W-1:0] repeat_period_r;

  // Poll state; the stored current word serves as the previous word of the next poll.
  logic [kpad_pkg::KEY_W-1:0]  cur_keys_r, cur_keys_nxt;
  kpad_pkg::key_pos_t          held_key_r, held_key_nxt;
  logic [kpad_pkg::TICK_W-1:0] last_fire_r, last_fire_nxt;
  logic                        repeating_r, repeating_nxt;

  // Output register.
  logic               out_valid_r;
  kpad_pkg::key_pos_t pressed_r, clicked_r, repeat_r;
  kpad_pkg::key_pos_t repeat_nxt;

  logic                         in_acc;
  kpad_pkg::key_pos_t           held_eff;
  kpad_pkg::match_t             match;
  logic [kpad_pkg::TICK_W-1:0]  elapsed;
  logic [kpad_pkg::DELAY_W-1:0] limit;
  logic                         due;

  // The input waits only while a finished result is stalled.
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  assign cur_keys_nxt  = in_key_word & WORD_MASK;
  assign held_eff      = in_clear_repeat ? '0 : held_key_r;

  kpad_match #(
    .NUM_KEYS (NUM_KEYS)
  ) u_match (
    .cur_keys  (cur_keys_nxt),
    .prev_keys (cur_keys_r),
    .held_key  (held_eff),
    .match     (match)
  );

  // Wrapping elapsed time against the current delay.
  assign elapsed = in_now - last_fire_r;
  assign limit   = repeating_r ? repeat_period_r : first_delay_r;
  assign due     = elapsed > {{(kpad_pkg::TICK_W - kpad_pkg::DELAY_W){1'b0}}, limit};

  // Click re-arms; otherwise the armed key repeats or is dropped on release.
  always_comb begin
    held_key_nxt  = held_eff;
    last_fire_nxt = last_fire_r;
    repeating_nxt = repeating_r;
    repeat_nxt    = '0;
    priority if (match.clicked != '0) begin
      held_key_nxt  = match.clicked;
      repeating_nxt = 1'b0;
      last_fire_nxt = in_now;
      repeat_nxt    = match.clicked;
    end else if (held_eff != '0 && match.held_down) begin
      if (due) begin
        repeating_nxt = 1'b1;
        last_fire_nxt = in_now;
        repeat_nxt    = held_eff;
      end
    end else begin
      held_key_nxt = '0;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_delay_r   <= kpad_pkg::FIRST_DELAY_RST;
      repeat_period_r <= kpad_pkg::REPEAT_PERIOD_RST;
    end else if (cfg_we) begin
      if (cfg_index == kpad_pkg::CFG_FIRST_DELAY) begin
        first_delay_r <= cfg_wdata;
      end
      if (cfg_index == kpad_pkg::CFG_REPEAT_PERIOD) begin
        repeat_period_r <= cfg_wdata;
      end
    end
  end

  // Poll state update at each accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_keys_r  <= '0;
      held_key_r  <= '0;
      last_fire_r <= '0;
      repeating_r <= 1'b0;
    end else if (in_acc) begin
      cur_keys_r  <= cur_keys_nxt;
      held_key_r  <= held_key_nxt;
      last_fire_r <= last_fire_nxt;
      repeating_r <= repeating_nxt;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload, loaded only when an item is accepted.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pressed_r <= match.pressed;
      clicked_r <= match.clicked;
      repeat_r  <= repeat_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pressed_key = pressed_r;
  assign out_clicked_key = clicked_r;
  assign out_repeat_key  = repeat_r;

  // A click is always reported as the repeat key.
  a_click_reported: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && clicked_r != '0) |-> (repeat_r == clicked_r))
    else $error("clicked key not reported as repeat key");

  // A clicked key is pressed, so the first pressed key is at or before it.
  a_click_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && clicked_r != '0) |-> (pressed_r != '0 && pressed_r <= clicked_r))
    else $error("clicked key without an earlier pressed key");

  // Only active table positions can be armed.
  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_key_r <= kpad_pkg::key_pos_t'(ACTIVE))
    else $error("armed key outside the active table");

  // A reported repeat leaves that key armed.
  a_repeat_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && repeat_nxt != '0) |=> (held_key_r == $past(repeat_nxt)))
    else $error("repeat key not armed after report");

  // A result that is not taken stays valid.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r)
    else $error("stalled result dropped");

endmodule

[rtl/core/kpad_match.sv]
// Priority matcher: finds the first pressed and first clicked table key.
`timescale 1ns / 1ps

module kpad_match #(
  parameter int NUM_KEYS = kpad_pkg::NUM_KEYS_DEF
) (
  input  logic [kpad_pkg::KEY_W-1:0] cur_keys,
  input  logic [kpad_pkg::KEY_W-1:0] prev_keys,
  input  kpad_pkg::key_pos_t         held_key,
  output kpad_pkg::match_t           match
);

  localparam int ACTIVE = (NUM_KEYS < kpad_pkg::TABLE_LEN) ? NUM_KEYS : kpad_pkg::TABLE_LEN;

  logic [kpad_pkg::TABLE_LEN-1:0] down_vec;
  logic [kpad_pkg::TABLE_LEN-1:0] click_vec;

  // Per-key down and click flags; keys beyond the active count never match.
  for (genvar g = 0; g < kpad_pkg::TABLE_LEN; g++) begin : g_key
    if (g < ACTIVE) begin : g_on
      assign down_vec[g]  = (cur_keys & kpad_pkg::KEY_MASKS[g]) == '0;
      assign click_vec[g] = down_vec[g] && ((prev_keys & kpad_pkg::KEY_MASKS[g]) != '0);
    end else begin : g_off
      assign down_vec[g]  = 1'b0;
      assign click_vec[g] = 1'b0;
    end
  end

  // Lowest position wins; scanning from the top lets the lowest overwrite.
  always_comb begin
    match = '0;
    for (int i = kpad_pkg::TABLE_LEN - 1; i >= 0; i--) begin
      if (down_vec[i]) begin
        match.pressed = kpad_pkg::key_pos_t'(i + 1);
      end
      if (click_vec[i]) begin
        match.clicked = kpad_pkg::key_pos_t'(i + 1);
      end
      if (down_vec[i] && (held_key == kpad_pkg::key_pos_t'(i + 1))) begin
        match.held_down = 1'b1;
      end
    end
  end

endmodule

[sim/keypad_click_and_autorepeat_chk.sv]
// Checker for the keypad block: watches both channels, predicts each result item and compares.
`timescale 1ns / 1ps

module keypad_click_and_autorepeat_chk (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [kpad_pkg::KEY_W-1:0]      in_key_word,
  input  logic [kpad_pkg::TICK_W-1:0]     in_now,
  input  logic                            in_clear_repeat,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  kpad_pkg::key_pos_t              out_pressed_key,
  input  kpad_pkg::key_pos_t              out_clicked_key,
  input  kpad_pkg::key_pos_t              out_repeat_key,
  input  logic                            cfg_we,
  input  logic [kpad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kpad_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              pending
);

  // Key table in priority order, position 1 first.
  localparam int KEY_COUNT = 12;
  localparam logic [kpad_pkg::KEY_W-1:0] POLL_MASKS [KEY_COUNT] = '{
    16'h0020, 16'h0040, 16'h0080, 16'h0100,
    16'h0200, 16'h0006, 16'h0002, 16'h0008,
    16'h0010, 16'h0400, 16'h0800, 16'h2000
  };
  localparam logic [kpad_pkg::DELAY_W-1:0] FIRST_DELAY_INIT   = 16'd500;
  localparam logic [kpad_pkg::DELAY_W-1:0] REPEAT_PERIOD_INIT = 16'd175;

  typedef struct packed {
    kpad_pkg::key_pos_t pressed;
    kpad_pkg::key_pos_t clicked;
    kpad_pkg::key_pos_t autorep;
  } poll_result_t;

  // Predicted block state and registers.
  logic [kpad_pkg::KEY_W-1:0]   older_word;
  logic [kpad_pkg::KEY_W-1:0]   newer_word;
  kpad_pkg::key_pos_t           armed_key;
  logic [kpad_pkg::TICK_W-1:0]  fire_stamp;
  logic                         repeating_now;
  logic [kpad_pkg::DELAY_W-1:0] first_delay;
  logic [kpad_pkg::DELAY_W-1:0] repeat_period;
  poll_result_t                 expected_polls [$];

  // A key is down when every bit of its mask is low.
  function automatic logic is_down(input logic [kpad_pkg::KEY_W-1:0] word, input int pos);
    return (word & POLL_MASKS[pos-1]) == '0;
  endfunction

  // Advance the predicted state by one poll and work out its result.
  task automatic predict_poll(input logic [kpad_pkg::KEY_W-1:0] key_word,
                              input logic [kpad_pkg::TICK_W-1:0] now,
                              input logic clr, output poll_result_t res);
    logic [kpad_pkg::TICK_W-1:0]  elapsed;
    logic [kpad_pkg::DELAY_W-1:0] limit;
    res = '0;
    older_word = newer_word;
    newer_word = key_word;
    if (clr) begin
      armed_key = '0;
    end
    for (int pos = 1; pos <= KEY_COUNT; pos++) begin
      if (res.pressed == '0 && is_down(newer_word, pos)) begin
        res.pressed = kpad_pkg::key_pos_t'(pos);
      end
      if (res.clicked == '0 && !is_down(older_word, pos) && is_down(newer_word, pos)) begin
        res.clicked = kpad_pkg::key_pos_t'(pos);
      end
    end
    // A click always re-arms; otherwise the armed key repeats or is dropped.
    if (res.clicked != '0) begin
      armed_key     = res.clicked;
      repeating_now = 1'b0;
      fire_stamp    = now;
      res.autorep   = res.clicked;
    end else if (armed_key != '0 && is_down(newer_word, int'(armed_key))) begin
      elapsed = now - fire_stamp;
      limit   = repeating_now ? repeat_period : first_delay;
      if (elapsed > kpad_pkg::TICK_W'(limit)) begin
        repeating_now = 1'b1;
        fire_stamp    = now;
        res.autorep   = armed_key;
      end
    end else begin
      armed_key = '0;
    end
  endtask

  task automatic compare_field(input string field, input kpad_pkg::key_pos_t want,
                               input kpad_pkg::key_pos_t got, inout int errs);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      errs++;
    end
  endtask

  // Results are checked before the item taken at the same edge is predicted.
  always @(posedge clk) begin : check_edge
    poll_result_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      older_word    = '0;
      newer_word    = '0;
      armed_key     = '0;
      fire_stamp    = '0;
      repeating_now = 1'b0;
      first_delay   = FIRST_DELAY_INIT;
      repeat_period = REPEAT_PERIOD_INIT;
      expected_polls.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_polls.size() == 0) begin
          $display("%0t: result item with none expected, got pressed %0d clicked %0d repeat %0d",
                   $time, out_pressed_key, out_clicked_key, out_repeat_key);
          errs++;
        end else begin
          want = expected_polls.pop_front();
          compare_field("pressed_key", want.pressed, out_pressed_key, errs);
          compare_field("clicked_key", want.clicked, out_clicked_key, errs);
          compare_field("repeat_key", want.autorep, out_repeat_key, errs);
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          kpad_pkg::CFG_FIRST_DELAY: begin
            first_delay = cfg_wdata;
          end
          kpad_pkg::CFG_REPEAT_PERIOD: begin
            repeat_period = cfg_wdata;
          end
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_poll(in_key_word, in_now, in_clear_repeat, want);
        expected_polls.push_back(want);
      end
      fail_count <= fail_count + errs;
      pending    <= expected_polls.size();
    end
  end

endmodule

[sim/keypad_click_and_autorepeat_tb.sv]
// Testbench top for the keypad block: clock, reset, poll stimulus, stalls and the verdict.
`timescale 1ns / 1ps

module keypad_click_and_autorepeat_tb;

  localparam int SETTLE_CYCLES   = 4;
  localparam int POLLS_PER_PHASE = 118;

  logic                            clk             = 1'b0;
  logic                            rst_n           = 1'b0;
  logic                            in_valid        = 1'b0;
  logic                            in_stall;
  logic [kpad_pkg::KEY_W-1:0]      in_key_word     = '1;
  logic [kpad_pkg::TICK_W-1:0]     in_now          = '0;
  logic                            in_clear_repeat = 1'b0;
  logic                            out_valid;
  logic                            out_stall       = 1'b0;
  kpad_pkg::key_pos_t              out_pressed_key;
  kpad_pkg::key_pos_t              out_clicked_key;
  kpad_pkg::key_pos_t              out_repeat_key;
  logic                            cfg_we          = 1'b0;
  logic [kpad_pkg::CFG_IDX_W-1:0]  cfg_index       = kpad_pkg::CFG_FIRST_DELAY;
  logic [kpad_pkg::CFG_DATA_W-1:0] cfg_wdata       = '0;
  int                              fail_count;
  int                              pending;

  // Idle and stall rates in percent, and the running key word and tick.
  int                              idle_pct   = 0;
  int                              stall_pct  = 0;
  logic [kpad_pkg::KEY_W-1:0]      held_word  = '1;
  logic [kpad_pkg::TICK_W-1:0]     tick_count = '0;

  always #4 clk = ~clk;

  keypad_click_and_autorepeat i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_key_word     (in_key_word),
    .in_now          (in_now),
    .in_clear_repeat (in_clear_repeat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pressed_key (out_pressed_key),
    .out_clicked_key (out_clicked_key),
    .out_repeat_key  (out_repeat_key),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  keypad_click_and_autorepeat_chk i_chk (.*);

  // The receiver stalls at random.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    #5000000;
    $display("keypad_click_and_autorepeat_tb failed");
    $finish;
  end

  // Offer one item, with random idle cycles first, and return after it is accepted.
  task automatic send_poll(input logic [kpad_pkg::KEY_W-1:0] word,
                           input logic [kpad_pkg::TICK_W-1:0] now, input logic clr);
    while ($urandom_range(99) < idle_pct) begin
      in_valid        <= 1'b0;
      in_key_word     <= kpad_pkg::KEY_W'($urandom);
      in_now          <= $urandom;
      in_clear_repeat <= 1'($urandom);
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_key_word     <= word;
    in_now          <= now;
    in_clear_repeat <= clr;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Stop sending and wait until every result item has been taken.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_delays(input logic [kpad_pkg::CFG_DATA_W-1:0] first_ticks,
                            input logic [kpad_pkg::CFG_DATA_W-1:0] period_ticks);
    cfg_we    <= 1'b1;
    cfg_index <= kpad_pkg::CFG_FIRST_DELAY;
    cfg_wdata <= first_ticks;
    @(negedge clk);
    cfg_index <= kpad_pkg::CFG_REPEAT_PERIOD;
    cfg_wdata <= period_ticks;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly keep the word; else release all, press one or two table keys, or take a random word.
  function automatic logic [kpad_pkg::KEY_W-1:0] next_key_word(
      input logic [kpad_pkg::KEY_W-1:0] prev);
    int roll;
    logic [kpad_pkg::KEY_W-1:0] word;
    roll = $urandom_range(99);
    if (roll < 55) begin
      word = prev;
    end else if (roll < 70) begin
      word = '1;
    end else if (roll < 85) begin
      word = ~kpad_pkg::KEY_MASKS[$urandom_range(kpad_pkg::TABLE_LEN - 1)];
    end else if (roll < 93) begin
      word = ~(kpad_pkg::KEY_MASKS[$urandom_range(kpad_pkg::TABLE_LEN - 1)] |
               kpad_pkg::KEY_MASKS[$urandom_range(kpad_pkg::TABLE_LEN - 1)]);
    end else begin
      word = kpad_pkg::KEY_W'($urandom);
    end
    // Bits outside the table toggle now and then.
    if ($urandom_range(4) == 0) begin
      word[0]     = 1'($urandom_range(1));
      word[15:14] = 2'($urandom_range(3));
    end
    return word;
  endfunction

  // Random polls; time mostly creeps forward, sometimes jumps or runs back.
  task automatic run_polls(input int count, input int span, input bit hold_off);
    int roll;
    for (int n = 0; n < count; n++) begin
      if (hold_off && n % 40 == 39) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        @(negedge clk);
      end
      held_word = next_key_word(held_word);
      roll = $urandom_range(99);
      if (roll < 80) begin
        tick_count += $urandom_range(span);
      end else if (roll < 88) begin
        tick_count += $urandom;
      end else if (roll < 94) begin
        tick_count -= $urandom_range(span + 1, 1);
      end
      send_poll(held_word, tick_count, ($urandom_range(9) == 0));
    end
  endtask

  initial begin
    logic [kpad_pkg::CFG_DATA_W-1:0] first_ticks;
    logic [kpad_pkg::CFG_DATA_W-1:0] period_ticks;
    int span;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed polls with the reset delays of 500 and 175 ticks.
    send_poll(16'h0000, 32'd0, 1'b0);         // all down on the first poll: no click
    send_poll(16'hFFFF, 32'd10, 1'b0);
    send_poll(16'hFFDF, 32'd1000, 1'b0);      // click on key 1
    send_poll(16'hFFDF, 32'd1500, 1'b0);      // exactly the first delay: no repeat
    send_poll(16'hFFDF, 32'd1501, 1'b0);      // first repeat
    send_poll(16'hFFDF, 32'd1676, 1'b0);      // exactly the period: no repeat
    send_poll(16'hFFDF, 32'd1677, 1'b0);      // second repeat
    send_poll(16'hFFDF, 32'd1677, 1'b1);      // disarmed while held
    send_poll(16'hFFDF, 32'd5000, 1'b0);      // still held, nothing armed
    send_poll(16'hFFF9, 32'd5001, 1'b0);      // two-bit key wins over its subset key
    send_poll(16'hFFFD, 32'd5002, 1'b0);      // subset key held over, armed key released
    send_poll(16'hFFFF, 32'd5003, 1'b0);
    send_poll(16'hDFFF, 32'hFFFF_FF00, 1'b1); // click with the disarm flag set
    send_poll(16'hDFFF, 32'h0000_0100, 1'b0); // tick wrap, elapsed 512
    send_poll(16'hDFFF, 32'h0000_0100, 1'b0);
    send_poll(16'h0000, 32'h0000_0200, 1'b0); // everything down at once
    send_poll(16'hFFFF, 32'h0000_0300, 1'b0);
    send_poll(16'h3FFE, 32'h0000_0400, 1'b0); // only bits outside the table low
    send_poll(16'hC001, 32'h0000_0500, 1'b0); // only bits outside the table high
    send_poll(16'hFFFF, 32'h0000_0600, 1'b0);
    tick_count = 32'h0000_0600;

    // Random phases, each with its own delays and idle pattern.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          first_ticks = '0; period_ticks = '0; span = 3;
          idle_pct = 0; stall_pct = 0;
        end
        1: begin
          first_ticks = '1; period_ticks = '1; span = 70000;
          idle_pct = 80; stall_pct = 0;
        end
        2: begin
          first_ticks = 16'($urandom_range(60)); period_ticks = 16'($urandom_range(60));
          span = 40; idle_pct = 0; stall_pct = 80;
        end
        3: begin
          first_ticks = 16'($urandom_range(60)); period_ticks = 16'($urandom_range(60));
          span = 40; idle_pct = 27; stall_pct = 27;
        end
        4: begin
          first_ticks = '1; period_ticks = '0; span = 70000;
          idle_pct = 0; stall_pct = 0;
        end
        5: begin
          first_ticks = '0; period_ticks = '1; span = 70000;
          idle_pct = 80; stall_pct = 0;
        end
        6: begin
          first_ticks = 16'($urandom); period_ticks = 16'($urandom); span = 65535;
          idle_pct = 0; stall_pct = 80;
        end
        default: begin
          first_ticks = 16'($urandom_range(20)); period_ticks = 16'($urandom_range(20));
          span = 25; idle_pct = 27; stall_pct = 27;
        end
      endcase
      wait_idle();
      set_delays(first_ticks, period_ticks);
      run_polls(POLLS_PER_PHASE, span, phase == 3);
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("keypad_click_and_autorepeat_tb passed");
    end else begin
      $display("keypad_click_and_autorepeat_tb failed");
    end
    $finish;
  end

endmodule
